// File: sv/mrr_pkg.sv
`default_nettype none
package mrr_pkg;

	localparam int MAX_FRAME_DEF = 256;
	localparam int POS_W = 9;
	localparam int LEN_CMP_W = 10;
	localparam int CFG_IDX_W = 3;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [POS_W-1:0] LEN_SINGLE_READ = 9'd7;
	localparam logic [POS_W-1:0] LEN_FIXED = 9'd8;
	localparam logic [POS_W-1:0] LEN_MULTI_BASE = 9'd5;

	localparam logic [7:0] RST_SLAVE_ADDRESS = 8'd1;
	localparam logic [7:0] RST_CODE_SINGLE_READ = 8'd4;
	localparam logic [7:0] RST_CODE_SINGLE_WRITE = 8'd6;
	localparam logic [7:0] RST_CODE_MULTI_READ = 8'd3;
	localparam logic [7:0] RST_CODE_MULTI_WRITE = 8'd16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SLAVE_ADDRESS = 3'd0,
		REG_CODE_SINGLE_READ = 3'd1,
		REG_CODE_SINGLE_WRITE = 3'd2,
		REG_CODE_MULTI_READ = 3'd3,
		REG_CODE_MULTI_WRITE = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_BUSY = 3'd0,
		ST_OK = 3'd1,
		ST_CRCERR = 3'd2,
		ST_DROP = 3'd3,
		ST_RESYNC = 3'd4,
		ST_OVERFLOW = 3'd5
	} status_t;

	typedef struct packed {
		logic [7:0] slave_address;
		logic [7:0] code_single_read;
		logic [7:0] code_single_write;
		logic [7:0] code_multi_read;
		logic [7:0] code_multi_write;
	} cfg_t;

	typedef struct packed {
		status_t status;
		logic [7:0] byte_position;
		logic [7:0] data_byte;
		logic [7:0] frame_function;
	} result_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0])
				c = (c >> 1) ^ CRC_POLY;
			else
				c = c >> 1;
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// File: sv/mrr_cfg.sv
`default_nettype none
module mrr_cfg (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_wr_en,
	input wire logic [mrr_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [7:0] cfg_data,
	output mrr_pkg::cfg_t cfg
);
	import mrr_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slave_address <= RST_SLAVE_ADDRESS;
			cfg_q.code_single_read <= RST_CODE_SINGLE_READ;
			cfg_q.code_single_write <= RST_CODE_SINGLE_WRITE;
			cfg_q.code_multi_read <= RST_CODE_MULTI_READ;
			cfg_q.code_multi_write <= RST_CODE_MULTI_WRITE;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_SLAVE_ADDRESS: cfg_q.slave_address <= cfg_data;
				REG_CODE_SINGLE_READ: cfg_q.code_single_read <= cfg_data;
				REG_CODE_SINGLE_WRITE: cfg_q.code_single_write <= cfg_data;
				REG_CODE_MULTI_READ: cfg_q.code_multi_read <= cfg_data;
				REG_CODE_MULTI_WRITE: cfg_q.code_multi_write <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// File: sv/mrr_frame.sv
`default_nettype none
module mrr_frame #(
	parameter int MAX_FRAME = mrr_pkg::MAX_FRAME_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire mrr_pkg::cfg_t cfg,
	input wire logic beat,
	input wire logic [7:0] rx_byte,
	output mrr_pkg::result_t result
);
	import mrr_pkg::*;

	localparam logic [LEN_CMP_W-1:0] MaxLen = LEN_CMP_W'(MAX_FRAME);

	logic [POS_W-1:0] pos_q;
	logic [7:0] func_q;
	logic [POS_W-1:0] exp_len_q;
	logic [15:0] crc_q;

	logic [POS_W-1:0] pos_d;
	logic [7:0] func_d;
	logic [POS_W-1:0] exp_len_d;
	logic [15:0] crc_d;

	logic is_sr, is_sw, is_mr, is_mw, byte_is_code;
	logic [POS_W-1:0] len;
	logic [LEN_CMP_W-1:0] pos_inc;
	logic [15:0] crc_run, crc_fresh;

	assign byte_is_code = (rx_byte == cfg.code_single_read) || (rx_byte == cfg.code_single_write)
		|| (rx_byte == cfg.code_multi_read) || (rx_byte == cfg.code_multi_write);

	assign is_sr = func_q == cfg.code_single_read;
	assign is_sw = func_q == cfg.code_single_write;
	assign is_mr = func_q == cfg.code_multi_read;
	assign is_mw = func_q == cfg.code_multi_write;

	// first match wins when code registers collide
	always_comb begin
		if (is_sr)
			len = LEN_SINGLE_READ;
		else if (is_sw)
			len = LEN_FIXED;
		else if (is_mr)
			len = LEN_MULTI_BASE + {1'b0, rx_byte};
		else if (is_mw)
			len = LEN_FIXED;
		else
			len = '0;
	end

	assign crc_run = crc_byte(crc_q, rx_byte);
	assign crc_fresh = crc_byte(CRC_INIT, rx_byte);
	assign pos_inc = {1'b0, pos_q} + LEN_CMP_W'(1);

	always_comb begin
		pos_d = pos_q;
		func_d = func_q;
		exp_len_d = exp_len_q;
		crc_d = crc_q;
		result.status = ST_BUSY;
		result.byte_position = pos_q[7:0];
		result.data_byte = rx_byte;
		result.frame_function = '0;

		if (pos_q == POS_W'(0)) begin
			if (rx_byte == cfg.slave_address) begin
				crc_d = crc_fresh;
				pos_d = POS_W'(1);
			end else begin
				result.status = ST_DROP;
			end
		end else if (pos_q == POS_W'(1)) begin
			if (byte_is_code) begin
				func_d = rx_byte;
				result.frame_function = rx_byte;
				crc_d = crc_run;
				pos_d = POS_W'(2);
			end else if (rx_byte == cfg.slave_address) begin
				// take this byte as the address of a new frame
				result.status = ST_RESYNC;
				result.byte_position = '0;
				func_d = '0;
				exp_len_d = '0;
				crc_d = crc_fresh;
				pos_d = POS_W'(1);
			end else begin
				result.status = ST_DROP;
				pos_d = '0;
				func_d = '0;
				exp_len_d = '0;
				crc_d = CRC_INIT;
			end
		end else if (pos_q == POS_W'(2)) begin
			if (len == '0) begin
				result.status = ST_DROP;
				pos_d = '0;
				func_d = '0;
				exp_len_d = '0;
				crc_d = CRC_INIT;
			end else if ({1'b0, len} > MaxLen) begin
				result.status = ST_OVERFLOW;
				pos_d = '0;
				func_d = '0;
				exp_len_d = '0;
				crc_d = CRC_INIT;
			end else begin
				result.frame_function = func_q;
				exp_len_d = len;
				crc_d = crc_run;
				pos_d = POS_W'(3);
			end
		end else begin
			result.frame_function = func_q;
			if (pos_inc >= {1'b0, exp_len_q}) begin
				result.status = (crc_run == 16'h0000) ? ST_OK : ST_CRCERR;
				pos_d = '0;
				func_d = '0;
				exp_len_d = '0;
				crc_d = CRC_INIT;
			end else begin
				crc_d = crc_run;
				pos_d = pos_inc[POS_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			func_q <= '0;
			exp_len_q <= '0;
			crc_q <= CRC_INIT;
		end else if (beat) begin
			pos_q <= pos_d;
			func_q <= func_d;
			exp_len_q <= exp_len_d;
			crc_q <= crc_d;
		end
	end

endmodule
`default_nettype wire

// File: sv/mrr_skid.sv
`default_nettype none
module mrr_skid (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire mrr_pkg::result_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output mrr_pkg::result_t out_data
);
	import mrr_pkg::*;

	logic out_valid_q, skid_valid_q;
	result_t out_q, skid_q;
	logic take, beat;

	assign in_ready = !skid_valid_q;
	assign beat = in_valid && in_ready;
	assign take = out_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take)
				skid_valid_q <= 1'b0;
		end else if (beat) begin
			if (!out_valid_q || take)
				out_valid_q <= 1'b1;
			else
				skid_valid_q <= 1'b1;
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take)
				out_q <= skid_q;
		end else if (beat) begin
			if (!out_valid_q || take)
				out_q <= in_data;
			else
				skid_q <= in_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule
`default_nettype wire

// File: sv/modbus_rtu_response_receiver.sv
// Each byte's result is registered in the output buffer before it shows at out_valid.
// One byte per cycle while in_ready is high; CRC and position steps are combinational.
// A two-entry output buffer keeps in_ready high while one result waits downstream.
// Reset: frame state clears (position 0, CRC 0xFFFF), code registers take their defaults,
// and the output buffer empties.
`default_nettype none
module modbus_rtu_response_receiver #(
	parameter int MAX_FRAME = mrr_pkg::MAX_FRAME_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [7:0] rx_byte,
	output logic out_valid,
	input wire logic out_ready,
	output logic [2:0] status,
	output logic [7:0] byte_position,
	output logic [7:0] data_byte,
	output logic [7:0] frame_function,
	input wire logic cfg_wr_en,
	input wire logic [mrr_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [7:0] cfg_data
);
	import mrr_pkg::*;

	cfg_t cfg;
	result_t res_next, res_out;
	logic ready;

	mrr_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	mrr_frame #(
		.MAX_FRAME(MAX_FRAME)
	) u_frame (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.beat(in_valid && ready),
		.rx_byte(rx_byte),
		.result(res_next)
	);

	mrr_skid u_skid (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(ready),
		.in_data(res_next),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(res_out)
	);

	assign in_ready = ready;
	assign status = res_out.status;
	assign byte_position = res_out.byte_position;
	assign data_byte = res_out.data_byte;
	assign frame_function = res_out.frame_function;

endmodule
`default_nettype wire

// File: test/modbus_rtu_response_receiver_test.sv
`timescale 1ns / 100ps
module modbus_rtu_response_receiver_test;
	import mrr_pkg::*;

	localparam int FRAME_LIMIT = MAX_FRAME_DEF;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int REPORT_CAP = 100;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] rx_byte = 8'h00;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] status;
	logic [7:0] byte_position;
	logic [7:0] data_byte;
	logic [7:0] frame_function;
	logic cfg_wr_en = 1'b0;
	reg_idx_t cfg_index = REG_SLAVE_ADDRESS;
	logic [7:0] cfg_data = 8'h00;

	modbus_rtu_response_receiver #(
		.MAX_FRAME(FRAME_LIMIT)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.byte_position(byte_position),
		.data_byte(data_byte),
		.frame_function(frame_function),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// receiver shadow: register copy and frame tracking state
	cfg_t cfg;
	logic [8:0] fr_pos;
	logic [7:0] fr_func;
	logic [8:0] fr_len;
	logic [15:0] fr_crc;

	logic [7:0] line_bytes_q[$];
	result_t byte_results_q[$];

	int errors = 0;
	int phase_bytes = 0;
	int n_bytes_sent = 0;
	int n_settings = 1;
	int status_seen[6];
	int in_gap_left = 0;
	int out_stall_left = 0;
	bit in_idle_on = 1'b1;
	bit out_idle_on = 1'b1;
	int unsigned cycle_count = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] d);
		logic [15:0] r;
		r = acc ^ {8'h00, d};
		repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		return r;
	endfunction

	// zero means the byte is no function code
	function automatic int frame_len(input logic [7:0] f, input logic [7:0] cnt);
		if (f == cfg.code_single_read) return int'(LEN_SINGLE_READ);
		if (f == cfg.code_single_write) return int'(LEN_FIXED);
		if (f == cfg.code_multi_read) return int'(LEN_MULTI_BASE) + int'(cnt);
		if (f == cfg.code_multi_write) return int'(LEN_FIXED);
		return 0;
	endfunction

	function automatic void clear_frame();
		fr_pos = '0;
		fr_func = 8'h00;
		fr_len = '0;
		fr_crc = CRC_INIT;
	endfunction

	function automatic result_t track_frame(input logic [7:0] b);
		result_t r;
		logic [8:0] pos;
		int len;
		pos = fr_pos;
		r.status = ST_BUSY;
		r.data_byte = b;
		r.frame_function = 8'h00;
		if (pos == 0) begin
			if (b == cfg.slave_address) begin
				fr_crc = crc16_step(CRC_INIT, b);
				fr_pos = 9'd1;
			end else begin
				r.status = ST_DROP;
				clear_frame();
			end
		end else if (pos == 1) begin
			if (frame_len(b, 8'h00) != 0) begin
				fr_func = b;
				r.frame_function = b;
				fr_crc = crc16_step(fr_crc, b);
				fr_pos = 9'd2;
			end else if (b == cfg.slave_address) begin
				// restart on this byte as a new address
				r.status = ST_RESYNC;
				pos = '0;
				clear_frame();
				fr_crc = crc16_step(CRC_INIT, b);
				fr_pos = 9'd1;
			end else begin
				r.status = ST_DROP;
				clear_frame();
			end
		end else if (pos == 2) begin
			len = frame_len(fr_func, b);
			if (len == 0) begin
				r.status = ST_DROP;
				clear_frame();
			end else if (len > FRAME_LIMIT) begin
				r.status = ST_OVERFLOW;
				clear_frame();
			end else begin
				r.frame_function = fr_func;
				fr_len = 9'(len);
				fr_crc = crc16_step(fr_crc, b);
				fr_pos = 9'd3;
			end
		end else begin
			r.frame_function = fr_func;
			fr_crc = crc16_step(fr_crc, b);
			if (int'(pos) + 1 >= int'(fr_len)) begin
				r.status = (fr_crc == 16'h0000) ? ST_OK : ST_CRCERR;
				clear_frame();
			end else begin
				fr_pos = pos + 9'd1;
			end
		end
		r.byte_position = pos[7:0];
		return r;
	endfunction

	function automatic int idle_len(input bit on);
		int r;
		if (!on) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	// driver: one beat per handshake, optional gap after each beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				byte_results_q.push_back(track_frame(rx_byte));
				n_bytes_sent++;
			end
			if (!in_valid || in_ready) begin
				if (in_gap_left > 0) begin
					in_gap_left--;
					in_valid <= 1'b0;
				end else if (line_bytes_q.size() > 0) begin
					in_valid <= 1'b1;
					rx_byte <= line_bytes_q.pop_front();
					in_gap_left = idle_len(in_idle_on);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic report_field(input string name, input int expv, input int actv,
			input logic [7:0] b);
		errors++;
		if (errors <= REPORT_CAP)
			$display("%0t: %s mismatch on byte 0x%02h: expected %0d, actual %0d",
				$time, name, b, expv, actv);
	endtask

	// monitor: compare each result beat against the oldest expectation
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (byte_results_q.size() == 0) begin
					errors++;
					if (errors <= REPORT_CAP)
						$display("%0t: unexpected result: expected none, actual status %0d pos %0d",
							$time, status, byte_position);
				end else begin
					want = byte_results_q.pop_front();
					status_seen[want.status]++;
					if (status !== want.status)
						report_field("status", want.status, status, want.data_byte);
					if (byte_position !== want.byte_position)
						report_field("byte_position", want.byte_position, byte_position,
							want.data_byte);
					if (data_byte !== want.data_byte)
						report_field("data_byte", want.data_byte, data_byte, want.data_byte);
					if (frame_function !== want.frame_function)
						report_field("frame_function", want.frame_function, frame_function,
							want.data_byte);
				end
			end
			if (out_stall_left > 0) begin
				out_stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				out_stall_left = idle_len(out_idle_on);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, byte_results_q.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b);
		line_bytes_q.push_back(b);
		phase_bytes++;
	endtask

	// well-formed frame for the current setting (one bit flipped when bad_crc is set), or a short
	// prefix where the function is unknown or the length overflows
	task automatic add_frame(input logic [7:0] func, input logic [7:0] b2, input bit bad_crc);
		logic [7:0] fb[$];
		logic [15:0] c;
		int len;
		int k;
		fb.push_back(cfg.slave_address);
		fb.push_back(func);
		fb.push_back(b2);
		len = frame_len(func, b2);
		if (len >= 5 && len <= FRAME_LIMIT) begin
			while (fb.size() < len - 2) fb.push_back(8'($urandom));
			c = CRC_INIT;
			foreach (fb[j]) c = crc16_step(c, fb[j]);
			fb.push_back(c[7:0]);
			fb.push_back(c[15:8]);
			if (bad_crc) begin
				k = $urandom_range(3, len - 1);
				fb[k] = fb[k] ^ 8'(1 << $urandom_range(0, 7));
			end
		end
		foreach (fb[j]) send_byte(fb[j]);
	endtask

	function automatic logic [7:0] pick_code();
		case ($urandom_range(0, 19))
			0: return 8'($urandom);
			1, 2, 3, 4, 5: return cfg.code_single_read;
			6, 7, 8, 9: return cfg.code_single_write;
			10, 11, 12, 13, 14: return cfg.code_multi_read;
			default: return cfg.code_multi_write;
		endcase
	endfunction

	task automatic wait_idle();
		while (line_bytes_q.size() != 0 || in_valid || byte_results_q.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [7:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
	endtask

	task automatic apply_config(input cfg_t c);
		write_reg(REG_SLAVE_ADDRESS, c.slave_address);
		write_reg(REG_CODE_SINGLE_READ, c.code_single_read);
		write_reg(REG_CODE_SINGLE_WRITE, c.code_single_write);
		write_reg(REG_CODE_MULTI_READ, c.code_multi_read);
		write_reg(REG_CODE_MULTI_WRITE, c.code_multi_write);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cfg = c;
		n_settings++;
		@(negedge clk);
	endtask

	task automatic run_phase(input int n_items, input bit in_idle, input bit out_idle,
			input bit end_mid_frame);
		int sel;
		int k;
		logic [7:0] b2;
		logic [7:0] filler;
		in_idle_on = in_idle;
		out_idle_on = out_idle;
		phase_bytes = 0;
		while (phase_bytes < n_items) begin
			sel = $urandom_range(0, 99);
			// byte count mostly small, now and then anything up to overflow
			b2 = ($urandom_range(0, 24) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20));
			if (sel < 75) begin
				add_frame(pick_code(), b2, $urandom_range(0, 6) == 0);
			end else if (sel < 85) begin
				repeat ($urandom_range(1, 4))
					send_byte(($urandom_range(0, 2) == 0) ? cfg.slave_address : 8'($urandom));
			end else if (sel < 93) begin
				send_byte(cfg.slave_address);
				send_byte(pick_code());
				repeat ($urandom_range(0, 4)) send_byte(8'($urandom));
			end else begin
				send_byte(cfg.slave_address);
				add_frame(pick_code(), b2, 1'b0);
			end
		end
		wait_idle();
		// walk the receiver back to position 0 with a byte that is neither
		// address nor function code
		filler = 8'h00;
		for (k = 255; k >= 0; k--)
			if (8'(k) != cfg.slave_address && frame_len(8'(k), 8'h00) == 0) filler = 8'(k);
		while (fr_pos != 0) begin
			send_byte(filler);
			wait_idle();
		end
		if (end_mid_frame) begin
			// leave a frame open at position 2 across the register change
			send_byte(cfg.slave_address);
			send_byte(cfg.code_single_read);
			wait_idle();
		end
	endtask

	initial begin
		cfg_t c;
		cfg = {RST_SLAVE_ADDRESS, RST_CODE_SINGLE_READ, RST_CODE_SINGLE_WRITE,
			RST_CODE_MULTI_READ, RST_CODE_MULTI_WRITE};
		clear_frame();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: wrong address at both extremes, resync into a good frame,
		// unknown function, overflow, shortest multiple read with a bad CRC, then a multiple write
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(cfg.slave_address);
		add_frame(cfg.code_single_read, 8'hA5, 1'b0);
		send_byte(cfg.slave_address);
		send_byte(8'hFF);
		add_frame(cfg.code_multi_read, 8'hFF, 1'b0);
		add_frame(cfg.code_multi_read, 8'h00, 1'b1);
		add_frame(cfg.code_multi_write, 8'h00, 1'b0);
		wait_idle();

		run_phase(300, 1'b1, 1'b1, 1'b1);
		// address 0, extreme codes, single write code equal to the address
		apply_config({8'h00, 8'hFF, 8'h00, 8'h80, 8'h7F});
		run_phase(350, 1'b1, 1'b0, 1'b0);
		// all codes equal: single read wins
		apply_config({8'hFF, 8'h41, 8'h41, 8'h41, 8'h41});
		run_phase(300, 1'b0, 1'b0, 1'b0);
		// pairs of equal codes
		apply_config({8'h5A, 8'h06, 8'h06, 8'h03, 8'h03});
		run_phase(300, 1'b0, 1'b1, 1'b1);
		repeat (2) begin
			c = {8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
			if ($urandom_range(0, 2) == 0) c.code_multi_write = c.code_single_read;
			apply_config(c);
			run_phase(280, 1'b1, 1'b1, 1'b0);
		end
		wait_idle();
		repeat (10) @(negedge clk);

		$display("%0d bytes over %0d register settings, %0d cycles", n_bytes_sent,
			n_settings, cycle_count);
		$display("ok %0d, crc error %0d, dropped %0d, resync %0d, overflow %0d, busy %0d",
			status_seen[ST_OK], status_seen[ST_CRCERR], status_seen[ST_DROP],
			status_seen[ST_RESYNC], status_seen[ST_OVERFLOW], status_seen[ST_BUSY]);
		if (errors == 0 && byte_results_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches, %0d results outstanding", errors, byte_results_q.size());
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// File: files.f
sv/mrr_pkg.sv
sv/mrr_cfg.sv
sv/mrr_frame.sv
sv/mrr_skid.sv
sv/modbus_rtu_response_receiver.sv
test/modbus_rtu_response_receiver_test.sv
